>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define AST_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/sott_pkg.sv
`default_nettype none

package sott_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int FIRE_LIMIT  = 16;
	localparam int FIRE_CNT_W  = $clog2(FIRE_LIMIT + 1);
	localparam int S_DATA_W    = 64;
	localparam int M_DATA_W    = 48;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_REJECTED = 3'd1;
	localparam logic [2:0] KIND_FIRED    = 3'd2;
	localparam logic [2:0] KIND_NO_FIRE  = 3'd3;
	localparam logic [2:0] KIND_CLEARED  = 3'd4;

	typedef struct packed {
		logic [15:0] ord_id;
		logic [15:0] volume;
		logic [31:0] price;
		logic [7:0]  instrument;
		logic        offset_flag;
		logic        direction;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        send;
		logic        fired_offset;
		logic        fired_direction;
		logic [15:0] fired_volume;
		logic [7:0]  fired_instrument;
		logic [15:0] ord_id;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/stop_order_trigger_table.sv
// Add, clear and rejected add: one transaction out, loaded in ST_OUT once the output register
//   is free, so it may wait on m_tready.
// Price tick: stored orders are scanned in turn through the single read port and price comparator,
//   then ST_FIN and ST_OUT close; each fired order beyond the first may wait on m_tready.
// The input is taken again once the final transaction of an item sits in the output register.
// Reset clears the order count, order id counter, send_enable and all handshake state.
`default_nettype none

`include "assert_macros.svh"

module stop_order_trigger_table #(
	parameter int TABLE_DEPTH = sott_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// instrument[7:0], price[39:8], volume[55:40], direction[56], offset_flag[57], zeros
	input  wire logic [sott_pkg::S_DATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// ord_id[15:0], fired_instrument[23:16], fired_volume[39:24],
	// fired_direction[40], fired_offset[41], send[42], zeros
	output logic [sott_pkg::M_DATA_W-1:0]      m_tdata,
	// kind[2:0]
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_data
);
	import sott_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	entry_t                mem [TABLE_DEPTH];
	entry_t                rd_data_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  mem_we;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_data;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      n_q, i_q, w_q;
	logic [CNT_W-1:0]      i_nx;
	logic [FIRE_CNT_W-1:0] k_q;
	logic                  have_pend_q;
	result_t               pend_q;
	logic [15:0]           next_id_q;
	logic                  send_en_q;
	logic [7:0]            tick_inst_q;
	logic [31:0]           tick_price_q;
	logic                  m_tvalid_q;
	logic                  m_tlast_q;
	result_t               res_q;

	logic                  accept;
	logic                  out_free;
	logic                  table_full;
	logic [31:0]           cmp_a, cmp_b;
	logic                  cmp_le;
	logic                  hit;
	logic                  scan_step;
	logic                  push_out;
	logic                  final_out;
	entry_t                new_entry;

	assign new_entry = '{
		ord_id:      next_id_q,
		volume:      s_tdata[55:40],
		price:       s_tdata[39:8],
		instrument:  s_tdata[7:0],
		offset_flag: s_tdata[57],
		direction:   s_tdata[56]
	};

	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign table_full = (n_q >= CNT_W'(TABLE_DEPTH));
	assign i_nx       = i_q + 1'b1;

	// shared comparator: buy fires on order <= last, sell on last <= order
	assign cmp_a  = rd_data_q.direction ? tick_price_q : rd_data_q.price;
	assign cmp_b  = rd_data_q.direction ? rd_data_q.price : tick_price_q;
	assign cmp_le = (cmp_a <= cmp_b);
	assign hit    = (rd_data_q.instrument == tick_inst_q) &&
	                (k_q < FIRE_CNT_W'(FIRE_LIMIT)) && cmp_le;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser) inside
						CMD_ADD, CMD_CLEAR: state_d = ST_OUT;
						CMD_TICK:           state_d = (n_q == '0) ? ST_FIN : ST_SCAN;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_step && i_nx == n_q)
					state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		scan_step = 1'b0;
		push_out  = 1'b0;
		final_out = 1'b0;
		mem_we    = 1'b0;
		wr_addr   = n_q[IDX_W-1:0];
		wr_data   = new_entry;
		rd_addr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept && s_tuser == CMD_ADD && !table_full)
					mem_we = 1'b1;
			end
			ST_SCAN: begin
				// a second hit must first push the held one out
				scan_step = !hit || !have_pend_q || out_free;
				push_out  = hit && have_pend_q && out_free;
				rd_addr   = scan_step ? i_nx[IDX_W-1:0] : i_q[IDX_W-1:0];
				if (scan_step && !hit) begin
					mem_we  = 1'b1;
					wr_addr = w_q[IDX_W-1:0];
					wr_data = rd_data_q;
				end
			end
			ST_FIN: ;
			ST_OUT: final_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			w_q         <= '0;
			k_q         <= '0;
			have_pend_q <= 1'b0;
			next_id_q   <= '0;
			send_en_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				send_en_q <= cfg_data;
			if (state_q == ST_IDLE && accept) begin
				unique case (s_tuser)
					CMD_ADD: begin
						if (!table_full) begin
							n_q       <= n_q + 1'b1;
							next_id_q <= next_id_q + 1'b1;
						end
					end
					CMD_TICK: begin
						i_q         <= '0;
						w_q         <= '0;
						k_q         <= '0;
						have_pend_q <= 1'b0;
					end
					CMD_CLEAR: n_q <= '0;
					default: ;
				endcase
			end
			if (scan_step) begin
				i_q <= i_nx;
				if (hit) begin
					k_q         <= k_q + 1'b1;
					have_pend_q <= 1'b1;
				end else begin
					w_q <= w_q + 1'b1;
				end
			end
			if (state_q == ST_FIN)
				n_q <= w_q;
			if (push_out || final_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			tick_inst_q  <= s_tdata[7:0];
			tick_price_q <= s_tdata[39:8];
			if (s_tuser == CMD_ADD && !table_full)
				pend_q <= '{kind: KIND_ADDED, ord_id: next_id_q, default: '0};
			else if (s_tuser == CMD_ADD)
				pend_q <= '{kind: KIND_REJECTED, default: '0};
			else
				pend_q <= '{kind: KIND_CLEARED, default: '0};
		end
		if (scan_step && hit) begin
			pend_q <= '{
				kind:             KIND_FIRED,
				send:             send_en_q,
				fired_offset:     rd_data_q.offset_flag,
				fired_direction:  rd_data_q.direction,
				fired_volume:     rd_data_q.volume,
				fired_instrument: rd_data_q.instrument,
				ord_id:           rd_data_q.ord_id
			};
		end
		if (state_q == ST_FIN && !have_pend_q)
			pend_q <= '{kind: KIND_NO_FIRE, default: '0};
		if (push_out || final_out) begin
			res_q     <= pend_q;
			m_tlast_q <= final_out;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tlast   = m_tlast_q;
	assign m_tuser   = res_q.kind;
	assign m_tdata   = {5'd0, res_q.send, res_q.fired_offset, res_q.fired_direction,
	                    res_q.fired_volume, res_q.fired_instrument, res_q.ord_id};

	`AST_HOLDS(a_cnt_bound, n_q <= CNT_W'(TABLE_DEPTH), "order count above table depth")
	`AST_HOLDS(a_wr_behind, (state_q != ST_SCAN) || (w_q <= i_q), "compaction write passed read")
	`AST_HOLDS(a_fire_cap, k_q <= FIRE_CNT_W'(FIRE_LIMIT), "fire count above limit")
	`AST_NEXT(a_add_grows, accept && s_tuser == CMD_ADD && !table_full, n_q == $past(n_q) + 1'b1, "add did not grow table")
	`AST_NEXT(a_clr_empty, accept && s_tuser == CMD_CLEAR, n_q == '0, "clear left orders")
	`AST_NEXT(a_fin_last, final_out, m_tvalid_q && m_tlast_q, "final transaction not marked last")

endmodule

`default_nettype wire

>>> tb/stop_order_trigger_table_tb.sv
`timescale 1ns / 1ps

module stop_order_trigger_table_tb;
	import sott_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		result_t r;
		logic    last;
	} outcome_t;

	class trigger_scoreboard;
		entry_t   book[$];
		logic [15:0] next_id;
		logic     send_en;
		outcome_t expected[$];
		int       errors;

		function new();
			next_id = '0;
			send_en = 1'b0;
			errors = 0;
		endfunction

		function void set_send(logic v);
			send_en = v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void add_expect(outcome_t o);
			expected.insert(expected.size(), o);
		endfunction

		function outcome_t make_outcome(logic [2:0] kind, logic [15:0] id, entry_t e,
				logic snd, logic lst);
			outcome_t o;
			o.r = '0;
			o.r.kind = kind;
			o.r.ord_id = id;
			if (kind == KIND_FIRED) begin
				o.r.fired_instrument = e.instrument;
				o.r.fired_volume = e.volume;
				o.r.fired_direction = e.direction;
				o.r.fired_offset = e.offset_flag;
			end
			o.r.send = snd;
			o.last = lst;
			return o;
		endfunction

		// Accepted input transaction: update the book and queue what it should produce.
		function void note_input(logic [1:0] cmd, logic [63:0] data);
			entry_t   e;
			entry_t   keep[$];
			outcome_t prev;
			logic     have_prev;
			logic     hit;
			int       fired;

			e = '0;
			e.instrument = data[7:0];
			e.price = data[39:8];
			e.volume = data[55:40];
			e.direction = data[56];
			e.offset_flag = data[57];
			case (cmd)
				CMD_ADD: begin
					if (book.size() >= DEPTH) begin
						add_expect(make_outcome(KIND_REJECTED, '0, e, 1'b0, 1'b1));
					end else begin
						e.ord_id = next_id;
						book.insert(book.size(), e);
						add_expect(make_outcome(KIND_ADDED, next_id, e, 1'b0, 1'b1));
						next_id = next_id + 16'd1;
					end
				end
				CMD_TICK: begin
					fired = 0;
					have_prev = 1'b0;
					foreach (book[i]) begin
						hit = 1'b0;
						if (book[i].instrument == e.instrument && fired < FIRE_LIMIT) begin
							// buy triggers at or below the last price, sell at or above
							hit = book[i].direction ? (book[i].price >= e.price)
								: (book[i].price <= e.price);
						end
						if (hit) begin
							if (have_prev)
								add_expect(prev);
							prev = make_outcome(KIND_FIRED, book[i].ord_id, book[i],
								send_en, 1'b0);
							have_prev = 1'b1;
							fired++;
						end else begin
							keep.insert(keep.size(), book[i]);
						end
					end
					book = keep;
					if (have_prev) begin
						prev.last = 1'b1;
						add_expect(prev);
					end else begin
						add_expect(make_outcome(KIND_NO_FIRE, '0, e, 1'b0, 1'b1));
					end
				end
				CMD_CLEAR: begin
					book.delete();
					add_expect(make_outcome(KIND_CLEARED, '0, e, 1'b0, 1'b1));
				end
				default: begin
				end
			endcase
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [M_DATA_W-1:0] data, logic [2:0] kind, logic lst);
			outcome_t want;

			if (expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got kind %0d data %h last %b",
					$time, kind, data, lst);
				return;
			end
			want = expected.pop_front();
			field_check("kind", 32'(want.r.kind), 32'(kind));
			field_check("ord_id", 32'(want.r.ord_id), 32'(data[15:0]));
			field_check("fired_instrument", 32'(want.r.fired_instrument), 32'(data[23:16]));
			field_check("fired_volume", 32'(want.r.fired_volume), 32'(data[39:24]));
			field_check("fired_direction", 32'(want.r.fired_direction), 32'(data[40]));
			field_check("fired_offset", 32'(want.r.fired_offset), 32'(data[41]));
			field_check("send", 32'(want.r.send), 32'(data[42]));
			field_check("padding", '0, 32'(data[M_DATA_W-1:43]));
			field_check("last", 32'(want.last), 32'(lst));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	trigger_scoreboard board;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int cycles = 0;

	stop_order_trigger_table #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Result side backpressure; a long hold-off is requested by the stimulus thread.
	initial begin
		int stall_left;

		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] pack_order(logic [7:0] inst, logic [31:0] price,
			logic [15:0] vol, logic dir, logic off);
		return {6'b0, off, dir, vol, price, inst};
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [63:0] data);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		board.note_input(cmd, data);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		// unused commands leave nothing to wait for; give the block time to settle
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_send_enable(input logic v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.set_send(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(output logic [1:0] cmd, output logic [63:0] data);
		int r;
		logic [7:0] inst;
		logic [31:0] price;

		r = $urandom_range(0, 99);
		if (r < 50)
			cmd = CMD_ADD;
		else if (r < 91)
			cmd = CMD_TICK;
		else if (r < 96)
			cmd = CMD_CLEAR;
		else
			cmd = CMD_UNUSED;
		// a few instruments and a narrow price band so ticks actually hit orders
		inst = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 3));
		price = ($urandom_range(0, 3) == 0) ? 32'($urandom)
			: 32'd20000 + 32'($urandom_range(0, 400));
		data = pack_order(inst, price, 16'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic run_random(input int count, input bit with_hold);
		logic [1:0] cmd;
		logic [63:0] data;
		int n;

		n = 0;
		while (n < count) begin
			random_item(cmd, data);
			send_item(cmd, data);
			if (cmd != CMD_UNUSED) begin
				n++;
				if (with_hold && n == 30)
					hold_req = 1'b1;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_send_enable(1'b1);
		send_item(CMD_TICK, pack_order(8'd7, 32'd5, 16'd0, 1'b0, 1'b0));
		send_item(CMD_ADD, pack_order(8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
		send_item(CMD_ADD, pack_order(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
		send_item(CMD_ADD, pack_order(8'd0, 32'hFFFF_FFFF, 16'h5A5A, 1'b0, 1'b1));
		send_item(CMD_TICK, pack_order(8'd0, 32'd0, 16'hFFFF, 1'b1, 1'b1));
		send_item(CMD_TICK, pack_order(8'hFF, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0));
		send_item(CMD_TICK, pack_order(8'hFF, 32'd0, 16'd0, 1'b0, 1'b0));
		send_item(CMD_UNUSED, pack_order(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
		// fill the book, then one add past full
		for (int i = 0; i < DEPTH - 1; i++)
			send_item(CMD_ADD, pack_order(8'd9, 32'd100, 16'(i), 1'(i), 1'(i >> 1)));
		send_item(CMD_ADD, pack_order(8'd9, 32'd100, 16'd77, 1'b0, 1'b0));
		// equal price fires both buys and sells
		send_item(CMD_TICK, pack_order(8'd9, 32'd100, 16'd0, 1'b0, 1'b0));
		send_item(CMD_CLEAR, pack_order(8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
		send_item(CMD_CLEAR, pack_order(8'd0, 32'd0, 16'd0, 1'b0, 1'b0));

		write_send_enable(1'b0);
		run_random(80, 1'b1);
		write_send_enable(1'b1);
		run_random(80, 1'b0);
		drain();
		idle_on = 1'b0;
		write_send_enable(1'b0);
		run_random(80, 1'b0);
		drain();

		if (board.errors == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/sott_pkg.sv
rtl/stop_order_trigger_table.sv
tb/stop_order_trigger_table_tb.sv
